FILE: hdl/ebd_pkg.sv
// Shared types, codes and constants for the encoder and button event decoder.
package ebd_pkg;

  localparam int NUM_BUTTONS_DEF = 4;
  localparam int TIME_BITS_DEF   = 32;

  localparam int EV_W     = 4;
  localparam int CFG_AW   = 4;
  localparam int CFG_DW   = 32;

  // event codes
  localparam logic [EV_W-1:0] EV_NONE = 4'd0;
  localparam logic [EV_W-1:0] EV_CW   = 4'd1;
  localparam logic [EV_W-1:0] EV_CCW  = 4'd2;
  localparam int EV_SHORT_BASE = 3;
  localparam int EV_LONG_BASE  = 7;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_DEBOUNCE   = 2'd0;
  localparam logic [1:0] REG_LONG_PRESS = 2'd1;
  localparam logic [1:0] REG_LONG_EN    = 2'd2;
  localparam logic [1:0] REG_DETENT     = 2'd3;

  // register reset values
  localparam logic [15:0] DEBOUNCE_RST   = 16'd20;
  localparam logic [15:0] LONG_PRESS_RST = 16'd400;
  localparam logic [3:0]  LONG_EN_RST    = 4'd9;
  localparam logic [3:0]  DETENT_RST     = 4'd4;

  localparam logic [1:0] QUAD_RST = 2'd3;

  // accumulator saturation limits
  localparam logic signed [8:0] ACC_MAX = 9'sd127;
  localparam logic signed [8:0] ACC_MIN = -9'sd127;

  // full-step table, index {prev_a, prev_b, cur_a, cur_b}
  localparam logic signed [1:0] QUAD_TABLE [16] = '{
     2'sd0, -2'sd1,  2'sd1,  2'sd0,
     2'sd1,  2'sd0,  2'sd0, -2'sd1,
    -2'sd1,  2'sd0,  2'sd0,  2'sd1,
     2'sd0,  2'sd1, -2'sd1,  2'sd0
  };

  typedef enum logic [1:0] {
    MODE_RELEASED = 2'd0,
    MODE_PRESSED  = 2'd1,
    MODE_LONG     = 2'd2
  } btn_mode_t;

endpackage

FILE: hdl/encoder_and_button_event_decoder.sv
// Top level: quadrature decoder with debounced, long-press capable buttons.
// An accepted input beat's result beat is in the output register in the next cycle.
// Throughput: 1 beat per cycle unless in_stall holds it; the only loop is the per-sample
//   state update, which closes through combinational logic.
// in_stall rises only while a result beat waits in the output register under out_stall.
// Reset (rst_n, synchronous, active low): registers to defaults, pins high, accumulator 0,
//   all buttons released and high with zero timestamps, output register empty.
module encoder_and_button_event_decoder #(
  parameter int NUM_BUTTONS = ebd_pkg::NUM_BUTTONS_DEF,
  parameter int TIME_BITS   = ebd_pkg::TIME_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [31:0]                 in_now_ms,
  input  logic                        in_enc_a,
  input  logic                        in_enc_b,
  input  logic [NUM_BUTTONS-1:0]      in_button_levels,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ebd_pkg::EV_W-1:0]    out_event_code,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ebd_pkg::CFG_AW-1:0]  paddr,
  input  logic [ebd_pkg::CFG_DW-1:0]  pwdata,
  output logic [ebd_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [15:0] db_window_r;
  logic [15:0] long_hold_r;
  logic [3:0]  long_enable_r;
  logic [3:0]  counts_per_detent_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      db_window_r         <= ebd_pkg::DEBOUNCE_RST;
      long_hold_r         <= ebd_pkg::LONG_PRESS_RST;
      long_enable_r       <= ebd_pkg::LONG_EN_RST;
      counts_per_detent_r <= ebd_pkg::DETENT_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        ebd_pkg::REG_DEBOUNCE:   db_window_r         <= pwdata[15:0];
        ebd_pkg::REG_LONG_PRESS: long_hold_r         <= pwdata[15:0];
        ebd_pkg::REG_LONG_EN:    long_enable_r       <= pwdata[3:0];
        ebd_pkg::REG_DETENT:     counts_per_detent_r <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      ebd_pkg::REG_DEBOUNCE:   prdata = {16'd0, db_window_r};
      ebd_pkg::REG_LONG_PRESS: prdata = {16'd0, long_hold_r};
      ebd_pkg::REG_LONG_EN:    prdata = {28'd0, long_enable_r};
      ebd_pkg::REG_DETENT:     prdata = {28'd0, counts_per_detent_r};
      default:                 prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Handshake: a beat enters whenever the output register can take its result
  // ---------------------------------------------------------------------------
  logic                     out_valid_r;
  logic [ebd_pkg::EV_W-1:0] out_event_code_r;
  logic                     in_fire;

  assign in_stall = out_valid_r & out_stall;
  assign in_fire  = in_valid & ~in_stall;

  // timestamp folded to TIME_BITS; all time math wraps at that width
  logic [TIME_BITS-1:0] now_t;
  generate
    if (TIME_BITS <= 32) begin : g_now_trunc
      assign now_t = in_now_ms[TIME_BITS-1:0];
    end else begin : g_now_ext
      assign now_t = {{(TIME_BITS-32){1'b0}}, in_now_ms};
    end
  endgenerate

  // ---------------------------------------------------------------------------
  // Quadrature path: table lookup, saturating accumulate, detent check
  // ---------------------------------------------------------------------------
  logic [1:0]        quad_prev_r;
  logic signed [7:0] step_accum_r;
  logic signed [7:0] step_accum_nxt;
  logic [1:0]        quad_cur;
  logic signed [1:0] quad_delta;
  logic signed [8:0] acc_sum;
  logic signed [7:0] acc_sat;
  logic signed [7:0] detent_s;
  logic [3:0]        detent_u;
  logic              rot_hit;
  logic [ebd_pkg::EV_W-1:0] rot_code;

  assign quad_cur   = {in_enc_a, in_enc_b};
  assign quad_delta = ebd_pkg::QUAD_TABLE[{quad_prev_r, quad_cur}];
  assign acc_sum    = {step_accum_r[7], step_accum_r} + {{7{quad_delta[1]}}, quad_delta};
  // zero detent size behaves as one
  assign detent_u   = (counts_per_detent_r == 4'd0) ? 4'd1 : counts_per_detent_r;
  assign detent_s   = {4'd0, detent_u};

  always_comb begin
    if (acc_sum > ebd_pkg::ACC_MAX) begin
      acc_sat = ebd_pkg::ACC_MAX[7:0];
    end else if (acc_sum < ebd_pkg::ACC_MIN) begin
      acc_sat = ebd_pkg::ACC_MIN[7:0];
    end else begin
      acc_sat = acc_sum[7:0];
    end

    if (acc_sat >= detent_s) begin
      step_accum_nxt = acc_sat - detent_s;
      rot_hit        = 1'b1;
      rot_code       = ebd_pkg::EV_CW;
    end else if (acc_sat <= -detent_s) begin
      step_accum_nxt = acc_sat + detent_s;
      rot_hit        = 1'b1;
      rot_code       = ebd_pkg::EV_CCW;
    end else begin
      step_accum_nxt = acc_sat;
      rot_hit        = 1'b0;
      rot_code       = ebd_pkg::EV_NONE;
    end
  end

  // ---------------------------------------------------------------------------
  // Button path: every button computes its candidate step in parallel; a
  // priority chain then lets buttons run up to and including the first event.
  // ---------------------------------------------------------------------------
  ebd_pkg::btn_mode_t   btn_mode_r  [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] btn_level_r;
  logic [TIME_BITS-1:0] btn_chg_r   [NUM_BUTTONS];
  logic [TIME_BITS-1:0] btn_press_r [NUM_BUTTONS];

  ebd_pkg::btn_mode_t   mode_c  [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] level_c;
  logic [TIME_BITS-1:0] chg_c   [NUM_BUTTONS];
  logic [TIME_BITS-1:0] press_c [NUM_BUTTONS];
  logic [ebd_pkg::EV_W-1:0] code_c [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] hit_c;
  logic [NUM_BUTTONS-1:0] btn_run;
  logic [NUM_BUTTONS-1:0] btn_take;
  logic [NUM_BUTTONS-1:0] long_en;
  logic [NUM_BUTTONS-1:0] edge_ok;
  logic [ebd_pkg::EV_W-1:0] btn_code;
  logic                   blocked;

  // only the first four buttons have an enable bit
  assign long_en = NUM_BUTTONS'(long_enable_r);

  always_comb begin
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      mode_c[i]  = btn_mode_r[i];
      level_c[i] = btn_level_r[i];
      chg_c[i]   = btn_chg_r[i];
      press_c[i] = btn_press_r[i];
      code_c[i]  = ebd_pkg::EV_NONE;
      hit_c[i]   = 1'b0;

      // accepted edge: level differs and debounce window has passed
      edge_ok[i] = (in_button_levels[i] != btn_level_r[i]) &&
                   ((now_t - btn_chg_r[i]) > TIME_BITS'(db_window_r));
      if (edge_ok[i]) begin
        chg_c[i]   = now_t;
        level_c[i] = in_button_levels[i];
        if (!in_button_levels[i]) begin
          mode_c[i]  = ebd_pkg::MODE_PRESSED;
          press_c[i] = now_t;
        end else begin
          mode_c[i] = ebd_pkg::MODE_RELEASED;
          // release after a long event is silent
          if (btn_mode_r[i] == ebd_pkg::MODE_PRESSED) begin
            hit_c[i]  = 1'b1;
            code_c[i] = 4'(ebd_pkg::EV_SHORT_BASE + i);
          end
        end
      end

      // long press may fire in the press sample itself when the hold time is zero
      if (!hit_c[i] && mode_c[i] == ebd_pkg::MODE_PRESSED && long_en[i] &&
          ((now_t - press_c[i]) >= TIME_BITS'(long_hold_r))) begin
        mode_c[i] = ebd_pkg::MODE_LONG;
        hit_c[i]  = 1'b1;
        code_c[i] = 4'(ebd_pkg::EV_LONG_BASE + i);
      end
    end

    blocked  = rot_hit;
    btn_code = ebd_pkg::EV_NONE;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      btn_run[i]  = ~blocked;
      btn_take[i] = ~blocked & hit_c[i];
      if (!blocked && hit_c[i]) begin
        btn_code = code_c[i];
        blocked  = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // State update on each accepted beat
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quad_prev_r  <= ebd_pkg::QUAD_RST;
      step_accum_r <= '0;
      btn_level_r  <= '1;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        btn_mode_r[i]  <= ebd_pkg::MODE_RELEASED;
        btn_chg_r[i]   <= '0;
        btn_press_r[i] <= '0;
      end
    end else if (in_fire) begin
      quad_prev_r  <= quad_cur;
      step_accum_r <= step_accum_nxt;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        if (btn_run[i]) begin
          btn_mode_r[i]  <= mode_c[i];
          btn_level_r[i] <= level_c[i];
          btn_chg_r[i]   <= chg_c[i];
          btn_press_r[i] <= press_c[i];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: holds a result beat until taken, refills in the same cycle
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_event_code_r <= rot_hit ? rot_code : btn_code;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_event_code = out_event_code_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_fire_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted beat did not produce a result beat");

  a_accum_no_min: assert property (@(posedge clk) disable iff (!rst_n)
    step_accum_r != -8'sd128)
    else $error("step accumulator left its saturation range");

  a_one_button_event: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(btn_take))
    else $error("more than one button event in a beat");

  a_rot_freezes_buttons: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && rot_hit |=> $stable(btn_level_r))
    else $error("button state changed on a rotation beat");

endmodule

FILE: verif/ebd_tb_pkg.sv
// Event predictor and scoreboard for the encoder and button event decoder bench.
package ebd_tb_pkg;
  import ebd_pkg::*;

  // quadrature count change, indexed by {previous pins, current pins}
  localparam int ROT_DELTA [16] = '{
     0, -1,  1,  0,
     1,  0,  0, -1,
    -1,  0,  0,  1,
     0,  1, -1,  0
  };

  class ebd_event_scoreboard;
    // register copies
    bit [15:0] db_window;
    bit [15:0] long_hold;
    bit [3:0]  long_en;
    bit [3:0]  detent_cfg;
    // decoder state
    bit [1:0]  pins_prev;
    int        accum;
    btn_mode_t mode [4];
    bit        level_q [4];
    bit [31:0] last_edge_ms [4];
    bit [31:0] press_ms [4];
    // expected event codes, oldest first
    logic [EV_W-1:0] expected_events [$];
    int errors, samples, beats, rotations, shorts, longs;

    function void reset_state();
      db_window     = DEBOUNCE_RST;
      long_hold     = LONG_PRESS_RST;
      long_en       = LONG_EN_RST;
      detent_cfg    = DETENT_RST;
      pins_prev     = QUAD_RST;
      accum         = 0;
      for (int i = 0; i < 4; i++) begin
        mode[i]         = MODE_RELEASED;
        level_q[i]      = 1'b1;
        last_edge_ms[i] = '0;
        press_ms[i]     = '0;
      end
      expected_events.delete();
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_DEBOUNCE:   db_window     = value[15:0];
        REG_LONG_PRESS: long_hold     = value[15:0];
        REG_LONG_EN:    long_en       = value[3:0];
        REG_DETENT:     detent_cfg    = value[3:0];
        default: ;
      endcase
    endfunction

    function logic [EV_W-1:0] button_event(int i, bit [31:0] now, bit level);
      bit [31:0] since_edge;
      bit [31:0] held;
      btn_mode_t was;
      since_edge = now - last_edge_ms[i];
      if (level != level_q[i] && since_edge > {16'd0, db_window}) begin
        last_edge_ms[i] = now;
        level_q[i]      = level;
        if (!level) begin
          mode[i]     = MODE_PRESSED;
          press_ms[i] = now;
        end else begin
          was     = mode[i];
          mode[i] = MODE_RELEASED;
          if (was == MODE_PRESSED) return EV_W'(EV_SHORT_BASE + i);
        end
      end
      held = now - press_ms[i];
      if (mode[i] == MODE_PRESSED && long_en[i] && held >= {16'd0, long_hold}) begin
        mode[i] = MODE_LONG;
        return EV_W'(EV_LONG_BASE + i);
      end
      return EV_NONE;
    endfunction

    // accepted input beat: advance the state and queue its event code
    function void note_sample(bit [31:0] now, bit a, bit b, bit [3:0] levels);
      bit [1:0] pins;
      int detent;
      logic [EV_W-1:0] ev;
      pins  = {a, b};
      accum = accum + ROT_DELTA[{pins_prev, pins}];
      if (accum > 127) accum = 127;
      if (accum < -127) accum = -127;
      pins_prev = pins;
      detent = (detent_cfg == 0) ? 1 : int'(detent_cfg);
      ev = EV_NONE;
      if (accum >= detent) begin
        accum = accum - detent;
        ev = EV_CW;
      end else if (accum <= -detent) begin
        accum = accum + detent;
        ev = EV_CCW;
      end else begin
        for (int i = 0; i < 4 && ev == EV_NONE; i++)
          ev = button_event(i, now, levels[i]);
      end
      expected_events.push_back(ev);
      samples++;
    endfunction

    // accepted result beat
    function void check_event(logic [EV_W-1:0] actual);
      logic [EV_W-1:0] want;
      if (expected_events.size() == 0) begin
        $error("event_code: no beat expected, actual %0d", actual);
        errors++;
        return;
      end
      want = expected_events.pop_front();
      beats++;
      if (actual !== want) begin
        $error("event_code: expected %0d, actual %0d", want, actual);
        errors++;
      end
      if (want == EV_CW || want == EV_CCW) rotations++;
      else if (want >= EV_LONG_BASE) longs++;
      else if (want >= EV_SHORT_BASE) shorts++;
    endfunction

    function int waiting();
      return expected_events.size();
    endfunction
  endclass

endpackage

FILE: verif/tb.sv
// Top-level testbench for the encoder and button event decoder.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ebd_pkg::*;
  import ebd_tb_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASES        = 6;
  localparam int PHASE_SAMPLES = 155;
  localparam int HOLD_CYCLES   = 80;

  // full-step positions in clockwise order, as {a, b}
  localparam logic [1:0] GRAY [4] = '{2'd3, 2'd1, 2'd0, 2'd2};

  typedef struct {
    logic [15:0] debounce;
    logic [15:0] long_press;
    logic [3:0]  long_en;
    logic [3:0]  detent;
    int          step_max;   // usual time advance per sample
    int          jump_max;   // occasional longer advance
  } phase_cfg_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [31:0]            in_now_ms = '0;
  logic                   in_enc_a = 1'b1;
  logic                   in_enc_b = 1'b1;
  logic [3:0]             in_button_levels = 4'hF;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [EV_W-1:0]        out_event_code;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [CFG_AW-1:0]      paddr = '0;
  logic [CFG_DW-1:0]      pwdata = '0;
  logic [CFG_DW-1:0]      prdata;
  logic                   pready;

  ebd_event_scoreboard sb = new;

  int  send_idle_pct = 0;     // used by the stimulus process only
  int  recv_idle_pct = 0;     // changed by nonblocking writes, read by the receiver
  logic hold_req = 1'b0;      // toggled to ask the receiver for a long hold-off
  logic hold_ack = 1'b0;
  int  hold_left = 0;
  int  cycles = 0;
  int  cfg_writes = 0;

  // random sample generator state
  logic [31:0] gen_ms;
  int          gen_pos;
  bit          gen_cw;
  logic [1:0]  gen_pins;
  logic [3:0]  gen_buttons;

  encoder_and_button_event_decoder i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_now_ms        (in_now_ms),
    .in_enc_a         (in_enc_a),
    .in_enc_b         (in_enc_b),
    .in_button_levels (in_button_levels),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event_code   (out_event_code),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // Receiver: random stall per cycle; a hold-off request keeps stall high for a
  // counted stretch so the output register fills and in_stall must rise.
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Result monitor: values sampled here are the ones from before this edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_event(out_event_code);
  end

  // One input beat; returns once the block has taken it.
  task automatic send_sample(input logic [31:0] now, input logic [1:0] pins,
                             input logic [3:0] levels);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_now_ms        <= now;
    in_enc_a         <= pins[1];
    in_enc_b         <= pins[0];
    in_button_levels <= levels;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_sample(now, pins[1], pins[0], levels);
  endtask

  // Stop sending and wait for every outstanding event beat, then a short
  // margin for the output register stage.
  task automatic drain_events();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.waiting() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle; the register takes the value at
  // the edge where psel, penable, pwrite and pready are all high. The bus then
  // returns to idle before the next transfer.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.write_reg(idx, value);
    cfg_writes++;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_cfg(input phase_cfg_t c);
    write_reg(REG_DEBOUNCE,   {16'd0, c.debounce});
    write_reg(REG_LONG_PRESS, {16'd0, c.long_press});
    write_reg(REG_LONG_EN,    {28'd0, c.long_en});
    write_reg(REG_DETENT,     {28'd0, c.detent});
  endtask

  // Next random sample: mostly clean rotation and button presses with a
  // plausible clock, sometimes pin noise, level flurries and time jumps.
  task automatic next_random(input phase_cfg_t c);
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      if ($urandom_range(0, 9) == 0) gen_cw = ~gen_cw;
      gen_pos  = gen_cw ? (gen_pos + 1) % 4 : (gen_pos + 3) % 4;
      gen_pins = GRAY[gen_pos];
    end else if (r < 40) begin
      gen_pins = 2'($urandom_range(0, 3));
    end
    if ($urandom_range(0, 5) == 0)
      gen_buttons[$urandom_range(0, 3)] = ~gen_buttons[$urandom_range(0, 3)];
    if ($urandom_range(0, 19) == 0)
      gen_buttons = 4'($urandom_range(0, 15));
    r = $urandom_range(0, 99);
    if (r < 85)      gen_ms = gen_ms + $urandom_range(0, c.step_max);
    else if (r < 95) gen_ms = gen_ms + $urandom_range(0, c.jump_max);
    else if (r < 98) gen_ms = $urandom;
    else             gen_ms = gen_ms - $urandom_range(0, 50);
  endtask

  phase_cfg_t plan [PHASES];

  initial begin
    // defaults, zero extremes, full-scale extremes, small odd settings, then mixed extremes
    plan[0] = '{16'd20,    16'd400,   4'd9,  4'd4,  15,    500};
    plan[1] = '{16'd0,     16'd0,     4'd15, 4'd1,  3,     20};
    plan[2] = '{16'd65535, 16'd65535, 4'd0,  4'd8,  30000, 100000};
    plan[3] = '{16'd5,     16'd30,    4'd5,  4'd15, 8,     60};
    plan[4] = '{16'd2,     16'd12,    4'd10, 4'd2,  4,     30};
    plan[5] = '{16'd65535, 16'd0,     4'd15, 4'd0,  40000, 70000};

    sb.reset_state();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset settings: bounce rejected, short press, long press with
    // silent release, press on a button without long binding, one detent each way.
    send_sample(32'd100,  2'd3, 4'hF);
    send_sample(32'd130,  2'd3, 4'hE);
    send_sample(32'd140,  2'd3, 4'hF);
    send_sample(32'd200,  2'd3, 4'hF);
    send_sample(32'd300,  2'd3, 4'h7);
    send_sample(32'd750,  2'd3, 4'h7);
    send_sample(32'd800,  2'd3, 4'hF);
    send_sample(32'd900,  2'd3, 4'hD);
    send_sample(32'd1400, 2'd3, 4'hD);
    send_sample(32'd1500, 2'd3, 4'hF);
    send_sample(32'd1510, 2'd1, 4'hF);
    send_sample(32'd1520, 2'd0, 4'hF);
    send_sample(32'd1530, 2'd2, 4'hF);
    send_sample(32'd1540, 2'd3, 4'hF);
    send_sample(32'd1550, 2'd2, 4'hF);
    send_sample(32'd1560, 2'd0, 4'hF);
    send_sample(32'd1570, 2'd1, 4'hF);
    send_sample(32'd1580, 2'd3, 4'hF);
    drain_events();

    // Directed, zero debounce / zero long time / zero detent size: long event
    // in the same sample as the press, time wrap, illegal pin jump, rotation
    // taking priority over a pending release.
    apply_cfg('{16'd0, 16'd0, 4'd15, 4'd0, 0, 0});
    send_sample(32'hFFFF_FFFF, 2'd3, 4'hB);
    send_sample(32'd0, 2'd1, 4'hF);
    send_sample(32'd0, 2'd3, 4'hF);
    send_sample(32'd1, 2'd0, 4'hF);
    send_sample(32'd2, 2'd0, 4'h0);
    send_sample(32'd3, 2'd0, 4'hF);
    drain_events();

    gen_ms      = 32'd5000;
    gen_pos     = 2;
    gen_cw      = 1'b1;
    gen_pins    = 2'd0;
    gen_buttons = 4'hF;

    for (int p = 0; p < PHASES; p++) begin
      // backpressure profile: sender-light/receiver-heavy, then reversed, then none
      if (p < 2) begin
        send_idle_pct = 25;
        recv_idle_pct <= 83;
      end else if (p < 4) begin
        send_idle_pct = 83;
        recv_idle_pct <= 25;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct <= 0;
      end
      apply_cfg(plan[p]);
      for (int k = 0; k < PHASE_SAMPLES; k++) begin
        // long receiver hold-off while the sender keeps offering beats
        if (p == 1 && k == 60) hold_req <= ~hold_req;
        // sender pauses until every result is back
        if (p == 4 && k == 80) drain_events();
        next_random(plan[p]);
        send_sample(gen_ms, gen_pins, gen_buttons);
      end
      drain_events();
    end

    repeat (10) @(posedge clk);
    $display("tb: %0d samples, %0d event beats checked, %0d register writes",
             sb.samples, sb.beats, cfg_writes);
    $display("tb: %0d rotation, %0d short press, %0d long press events, %0d mismatches",
             sb.rotations, sb.shorts, sb.longs, sb.errors);
    if (sb.errors == 0 && sb.waiting() == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/ebd_pkg.sv
hdl/encoder_and_button_event_decoder.sv
verif/ebd_tb_pkg.sv
verif/tb.sv
